### src/sns_pkg.sv
// ----------------------------------------------------------------------------
// sns_pkg
// shared constants, types and functions for the sha-256 nonce search
// ----------------------------------------------------------------------------
package sns_pkg;

   localparam logic [31:0] NONCE_LIMIT   = 32'd2176782335;
   localparam logic [24:0] SEARCH_RESET  = 25'd10000000;
   localparam int          MAX_DIGITS    = 6;
   localparam int          ID_LEN        = 10;
   localparam int          BLOCK_LEN     = 12;
   localparam int          QUEUE_DEPTH   = 2;

   // register indexes on the csr port
   localparam logic [2:0] REG_ID_HI    = 3'd0;
   localparam logic [2:0] REG_ID_LO    = 3'd1;
   localparam logic [2:0] REG_BLK_HI   = 3'd2;
   localparam logic [2:0] REG_BLK_LO   = 3'd3;
   localparam logic [2:0] REG_TARGET   = 3'd4;
   localparam logic [2:0] REG_COUNT    = 3'd5;

   typedef struct packed {
      logic        empty;     // nothing to hash, report at once
      logic [31:0] nonce;
   } job_type;

   typedef struct packed {
      logic        found;
      logic [31:0] nonce;
      logic [47:0] prefix;
      logic [24:0] tried;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_DONE
   } search_state_type;

   function automatic logic [31:0] kround(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [255:0] hinit();
      return {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
   endfunction

   function automatic logic [7:0] b36_char(input logic [5:0] d);
      logic [7:0] c;
      if (d < 6'd10) c = 8'h30 + {2'b00, d};
      else           c = 8'h57 + {2'b00, d};
      return c;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### src/sns_front.sv
// ----------------------------------------------------------------------------
// sns_front
// accepts search requests, flags empty ranges and queues them for the engine
// ----------------------------------------------------------------------------
module sns_front
   import sns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_start_nonce,
   input  logic [24:0]   search_count,
   output logic          job_valid,
   input  logic          job_ready,
   output job_type       job
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type          q_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             push, pop;
   job_type          nj;

   assign req_ready = (cnt_ff != PW'(0) + (PW+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
   assign push      = req_valid & req_ready;
   assign job_valid = cnt_ff != '0;
   assign pop       = job_valid & job_ready;
   assign job       = q_ff[rd_ff];

   always_comb begin
      nj.nonce = req_start_nonce;
      nj.empty = (req_start_nonce > NONCE_LIMIT) || (search_count == '0);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= nj;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push lost");
   assert property (@(posedge clock) disable iff (reset)
      !push && pop |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("pop lost");

endmodule

### src/sns_core.sv
// ----------------------------------------------------------------------------
// sns_core
// iterative sha-256 compression, one round per cycle, 48-bit prefix out
// ----------------------------------------------------------------------------
module sns_core
   import sns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [511:0]  blk,
   output logic          done,
   output logic [47:0]   prefix
);

   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [255:0] h_ff, h_in;
   logic [255:0] iv;
   logic [5:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn, hi0, hi1;

   always_comb begin
      iv = hinit();
      {a, b, c, d, e, f, g, hh} = h_ff;
      t1 = hh + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & f) ^ (~e & g))
         + kround(rnd_ff) + w_ff[0];
      t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(w_ff[1],7) ^ rotr(w_ff[1],18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14],17) ^ rotr(w_ff[14],19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
      w_in[15] = wn;
      h_in    = {t1 + t2, a, b, c, d + t1, e, f, g};
      rnd_in  = rnd_ff + 1'b1;
      busy_in = busy_ff && (rnd_ff != 6'd63);
      done_in = busy_ff && (rnd_ff == 6'd63);
      if (start) begin
         for (int i = 0; i < 16; i++) w_in[i] = blk[511 - 32*i -: 32];
         h_in    = iv;
         rnd_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end
      hi0 = h_ff[255:224] + iv[255:224];
      hi1 = h_ff[223:192] + iv[223:192];
   end

   assign done   = done_ff;
   assign prefix = {hi0, hi1[31:16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rnd_ff <= rnd_in;
      h_ff   <= h_in;
      w_ff   <= w_in;
   end

   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("done without work");
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("start while busy");

endmodule

### src/sns_back.sv
// ----------------------------------------------------------------------------
// sns_back
// runs one search: digit conversion, message build, hash, compare, report
// ----------------------------------------------------------------------------
module sns_back
   import sns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   output logic          job_ready,
   input  job_type       job,
   input  logic [63:0]   id_hi,
   input  logic [15:0]   id_lo,
   input  logic [63:0]   blk_hi,
   input  logic [31:0]   blk_lo,
   input  logic [47:0]   target,
   input  logic [24:0]   search_count,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output result_type    rsp
);

   search_state_type st_ff, st_in;
   logic [31:0] nonce_ff, nonce_in, val_ff, val_in;
   logic [24:0] tried_ff, tried_in;
   logic [47:0] pfx_ff, pfx_in;
   logic        found_ff, found_in;
   logic [2:0]  dig_ff, dig_in;     // digit step, MAX_DIGITS+1 = launch
   logic [7:0]  ch_ff [MAX_DIGITS];
   logic [7:0]  ch_in [MAX_DIGITS];
   logic [2:0]  nd_ff, nd_in;
   logic        conv_ff, conv_in;
   logic        start;
   logic [511:0] blk;
   logic [31:0] q;
   logic [5:0]  r;
   logic [63:0] qm;
   logic [8:0]  bits;
   logic        core_done;
   logic [47:0] core_pfx;
   logic        last;

   sns_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .blk    (blk),
      .done   (core_done),
      .prefix (core_pfx)
   );

   // divide by 36 through reciprocal multiply and one correction
   always_comb begin
      qm = {32'd0, val_ff} * 64'd954437177;   // ceil(2^35/36)
      q  = 32'(qm >> 35);
      if (32'(q * 32'd36) > val_ff) q = q - 1'b1;
      r  = 6'(val_ff - 32'(q * 32'd36));
   end

   always_comb begin
      blk = '0;
      blk[511 -: 64]  = id_hi;
      blk[447 -: 16]  = id_lo;
      blk[431 -: 64]  = blk_hi;
      blk[367 -: 32]  = blk_lo;
      for (int i = 0; i < MAX_DIGITS; i++)
         if (3'(i) < nd_ff)
            blk[335 - 8*i -: 8] = ch_ff[3'(nd_ff - 3'(i) - 3'd1)];
      blk[335 - 8*nd_ff -: 8] = 8'h80;
      bits = 9'(8 * (ID_LEN + BLOCK_LEN)) + {3'd0, nd_ff, 3'd0};
      blk[8:0] = bits;
   end

   assign last = (nonce_ff == NONCE_LIMIT) || (tried_ff + 1'b1 >= search_count);

   always_comb begin
      st_in = st_ff; nonce_in = nonce_ff; val_in = val_ff; tried_in = tried_ff;
      pfx_in = pfx_ff; found_in = found_ff; dig_in = dig_ff; nd_in = nd_ff;
      conv_in = conv_ff; ch_in = ch_ff;
      job_ready = 1'b0; start = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               nonce_in = job.nonce; val_in = job.nonce; tried_in = '0;
               pfx_in = '0; found_in = 1'b0; nd_in = '0; dig_in = '0;
               conv_in = 1'b1;
               st_in = job.empty ? ST_DONE : ST_HASH;
            end
         end
         ST_HASH: begin
            if (conv_ff) begin
               ch_in[dig_ff] = b36_char(r);
               val_in = q;
               dig_in = dig_ff + 1'b1;
               if (q == '0 || dig_ff == 3'(MAX_DIGITS - 1)) begin
                  nd_in = dig_ff + 1'b1;
                  conv_in = 1'b0;
               end
            end else if (nd_ff != '0) begin
               start = 1'b1; nd_in = nd_ff;
               dig_in = '0;
               conv_in = 1'b0;
               nd_in = nd_ff;
               st_in = ST_HASH;
               // hold in a wait after launch by setting the dig_ff marker to 7
               dig_in = 3'd7;
               if (dig_ff == 3'd7) start = 1'b0;
               if (core_done) begin
                  start = 1'b0;
                  tried_in = tried_ff + 1'b1;
                  pfx_in = core_pfx;
                  if (core_pfx < target) begin
                     found_in = 1'b1; st_in = ST_DONE;
                  end else if (last) begin
                     st_in = ST_DONE;
                  end else begin
                     nonce_in = nonce_ff + 1'b1; val_in = nonce_ff + 1'b1;
                     dig_in = '0; nd_in = '0; conv_in = 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = st_ff == ST_DONE;
   assign rsp = '{found: found_ff, nonce: nonce_ff, prefix: pfx_ff, tried: tried_ff};

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
      if (reset) conv_ff <= 1'b0;
      else       conv_ff <= conv_in;
      nonce_ff <= nonce_in; val_ff <= val_in; tried_ff <= tried_in;
      pfx_ff <= pfx_in; found_ff <= found_in; dig_ff <= dig_in; nd_ff <= nd_in;
      ch_ff <= ch_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.found |-> rsp.prefix < target)
      else $error("hit above target");
   assert property (@(posedge clock) disable iff (reset)
      core_done |-> st_ff == ST_HASH)
      else $error("stray hash result");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.tried <= search_count)
      else $error("tried too many");

endmodule

### src/sha256_nonce_search.sv
// ----------------------------------------------------------------------------
// sha256_nonce_search
// proof-of-work nonce search over single-block sha-256
// ----------------------------------------------------------------------------
//  channel  | ports                  | role
//  req      | req_valid/ready        | start nonce of one search request
//  rsp      | rsp_valid/ready        | hit flag, nonce, prefix, count
//  csr      | psel..pready           | apb-style, 64-bit data, addr 8*i
//
//  each nonce is turned into base-36 digits (up to 6), one digit per cycle,
//  then the hash is launched, runs 64 rounds and its prefix is compared;
//  each request also has an accept step and a report step
//  one request is searched at a time; a two-entry queue buffers the next
//  reset is synchronous, active high, and restores control and register-file state to defaults
//  rsp stalls hold the engine in its report state; the queue keeps
//  accepting until both entries are taken, then req_ready drops
// ----------------------------------------------------------------------------
module sha256_nonce_search
   import sns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_start_nonce,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_found,
   output logic [31:0]   rsp_hit_nonce,
   output logic [47:0]   rsp_digest_prefix,
   output logic [24:0]   rsp_tried_count,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [5:0]    paddr,
   input  logic [63:0]   pwdata,
   output logic [63:0]   prdata,
   output logic          pready
);

   logic [63:0] id_hi_ff, blk_hi_ff;
   logic [15:0] id_lo_ff;
   logic [31:0] blk_lo_ff;
   logic [47:0] target_ff;
   logic [24:0] count_ff;
   logic        wr;
   logic [2:0]  idx;
   logic        job_valid, job_ready;
   job_type     job;
   result_type  rsp;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[5:3];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         id_hi_ff <= '0; id_lo_ff <= '0; blk_hi_ff <= '0; blk_lo_ff <= '0;
         target_ff <= '0; count_ff <= SEARCH_RESET;
      end else if (wr) begin
         unique case (idx)
            REG_ID_HI:  id_hi_ff  <= pwdata;
            REG_ID_LO:  id_lo_ff  <= pwdata[15:0];
            REG_BLK_HI: blk_hi_ff <= pwdata;
            REG_BLK_LO: blk_lo_ff <= pwdata[31:0];
            REG_TARGET: target_ff <= pwdata[47:0];
            REG_COUNT:  count_ff  <= pwdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ID_HI:  prdata = id_hi_ff;
         REG_ID_LO:  prdata = {48'd0, id_lo_ff};
         REG_BLK_HI: prdata = blk_hi_ff;
         REG_BLK_LO: prdata = {32'd0, blk_lo_ff};
         REG_TARGET: prdata = {16'd0, target_ff};
         REG_COUNT:  prdata = {39'd0, count_ff};
         default:    prdata = '0;
      endcase
   end

   sns_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_nonce (req_start_nonce),
      .search_count    (count_ff),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (job)
   );

   sns_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_ready    (job_ready),
      .job          (job),
      .id_hi        (id_hi_ff),
      .id_lo        (id_lo_ff),
      .blk_hi       (blk_hi_ff),
      .blk_lo       (blk_lo_ff),
      .target       (target_ff),
      .search_count (count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp)
   );

   assign rsp_found         = rsp.found;
   assign rsp_hit_nonce     = rsp.nonce;
   assign rsp_digest_prefix = rsp.prefix;
   assign rsp_tried_count   = rsp.tried;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sha-256 nonce search: a local sha-256 and
// base-36 model predicts every response, while handshake gaps, receiver
// stalls and register settings vary from phase to phase
// ----------------------------------------------------------------------------
module tb_top;
   import sns_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_start_nonce;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_found;
   logic [31:0] rsp_hit_nonce;
   logic [47:0] rsp_digest_prefix;
   logic [24:0] rsp_tried_count;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   sha256_nonce_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_start_nonce(req_start_nonce),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_hit_nonce(rsp_hit_nonce), .rsp_digest_prefix(rsp_digest_prefix),
      .rsp_tried_count(rsp_tried_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // 20 unit clock period
   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   // local copy of the register file
   logic [63:0] id_hi_q;
   logic [15:0] id_lo_q;
   logic [63:0] blk_hi_q;
   logic [31:0] blk_lo_q;
   logic [47:0] target_q;
   logic [24:0] count_q;

   // sha-256 round constants
   logic [31:0] round_k [64];
   logic [31:0] iv_words [8];

   result_type  pending_results [$];
   int          error_count;
   int          sent_count;
   int          hit_count;
   int          checked_total;

   // traffic shaping knobs
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_cycles;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // first six digest bytes for one nonce under the current registers
   function automatic logic [47:0] nonce_prefix(input logic [31:0] nonce);
      logic [7:0]  msg [64];
      logic [7:0]  digits [8];
      logic [31:0] w [64];
      logic [31:0] h [8];
      logic [31:0] v, s0, s1, t1, t2, e, a;
      logic [63:0] bit_len;
      int          nd, len;
      for (int i = 0; i < 64; i++) msg[i] = 8'h00;
      for (int i = 0; i < 8; i++) begin
         msg[i]      = id_hi_q[63 - 8*i -: 8];
         msg[10 + i] = blk_hi_q[63 - 8*i -: 8];
      end
      msg[8] = id_lo_q[15:8];
      msg[9] = id_lo_q[7:0];
      for (int i = 0; i < 4; i++) msg[18 + i] = blk_lo_q[31 - 8*i -: 8];
      // base-36, least significant digit first; zero is a single "0"
      v  = nonce;
      nd = 0;
      do begin
         digits[nd] = (v % 36 < 10) ? 8'h30 + 8'(v % 36) : 8'h57 + 8'(v % 36);
         v  = v / 36;
         nd = nd + 1;
      end while (v != 0 && nd < 8);
      for (int i = 0; i < nd; i++) msg[22 + i] = digits[nd - 1 - i];
      len      = 22 + nd;
      msg[len] = 8'h80;
      bit_len  = 64'(len) * 8;
      for (int i = 0; i < 8; i++) msg[56 + i] = bit_len[63 - 8*i -: 8];
      for (int i = 0; i < 16; i++)
         w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) h[i] = iv_words[i];
      for (int i = 0; i < 64; i++) begin
         e  = h[4];
         a  = h[0];
         t1 = h[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
              ((e & h[5]) ^ (~e & h[6])) + round_k[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
              ((a & h[1]) ^ (a & h[2]) ^ (h[1] & h[2]));
         h[7] = h[6]; h[6] = h[5]; h[5] = h[4]; h[4] = h[3] + t1;
         h[3] = h[2]; h[2] = h[1]; h[1] = h[0]; h[0] = t1 + t2;
      end
      h[0] = h[0] + iv_words[0];
      h[1] = h[1] + iv_words[1];
      return {h[0], h[1][31:16]};
   endfunction

   // whole search for one request
   function automatic result_type search_outcome(input logic [31:0] start);
      result_type r;
      logic [31:0] nonce;
      logic [24:0] tried;
      logic [47:0] pfx;
      nonce   = start;
      tried   = '0;
      pfx     = '0;
      r.found = 1'b0;
      if (nonce <= NONCE_LIMIT && count_q != 0) begin
         forever begin
            pfx   = nonce_prefix(nonce);
            tried = tried + 1;
            if (pfx < target_q) begin
               r.found = 1'b1;
               break;
            end
            if (nonce == NONCE_LIMIT || tried >= count_q) break;
            nonce = nonce + 1;
         end
      end
      r.nonce  = nonce;
      r.prefix = pfx;
      r.tried  = tried;
      return r;
   endfunction

   // apb write: setup cycle, then access cycle
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ID_HI:  id_hi_q  = value;
         REG_ID_LO:  id_lo_q  = value[15:0];
         REG_BLK_HI: blk_hi_q = value;
         REG_BLK_LO: blk_lo_q = value[31:0];
         REG_TARGET: target_q = value[47:0];
         REG_COUNT:  count_q  = value[24:0];
         default: ;
      endcase
   endtask

   task automatic program_all(input logic [63:0] idh, input logic [15:0] idl,
                              input logic [63:0] bh, input logic [31:0] bl,
                              input logic [47:0] tgt, input logic [24:0] cnt);
      csr_write(REG_ID_HI, idh);
      csr_write(REG_ID_LO, {48'd0, idl});
      csr_write(REG_BLK_HI, bh);
      csr_write(REG_BLK_LO, {32'd0, bl});
      csr_write(REG_TARGET, {16'd0, tgt});
      csr_write(REG_COUNT, {39'd0, cnt});
   endtask

   // one request; valid stays up across back-to-back requests
   task automatic send_request(input logic [31:0] start);
      int gaps;
      gaps = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(6, 1) : 0;
      if (gaps > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gaps - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_start_nonce <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(search_outcome(start));
      sent_count++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // engine may still be settling after the last response
      repeat (200) @(negedge clock);
   endtask

   function automatic logic [31:0] random_start();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return $urandom_range(NONCE_LIMIT, 0);
      if (pick < 70) return $urandom_range(2000, 0);
      if (pick < 85) return NONCE_LIMIT - $urandom_range(5, 0);
      return $urandom();
   endfunction

   // ---------------------------------------------------------------- tests

   // corner nonces, digit-count boundaries, special counts and targets
   task automatic test_directed();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // zero bytes in id and block, target 0 never hits
      program_all(64'd0, 16'd0, 64'd0, 32'd0, 48'd0, 25'd2);
      send_request(32'd0);
      send_request(32'd35);
      send_request(32'd1295);
      send_request(32'd46655);
      send_request(NONCE_LIMIT - 1);
      send_request(NONCE_LIMIT);
      send_request(NONCE_LIMIT + 1);
      send_request(32'hFFFF_FFFF);
      drain_results();
      // all-ones bytes, target max hits at once, count at its 25-bit top
      program_all(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 25'h1FF_FFFF);
      send_request(32'd0);
      send_request(32'h5555_5555);
      send_request(NONCE_LIMIT);
      drain_results();
      // big count with no hit stops at the largest nonce
      csr_write(REG_TARGET, 64'd0);
      send_request(NONCE_LIMIT - 3);
      drain_results();
      // count zero: nothing hashed
      csr_write(REG_COUNT, 64'd0);
      send_request(32'd77);
      send_request(32'hAAAA_AAAA);
      drain_results();
      // count past 2^24 but target 2^47 still ends quickly
      program_all(64'h6b72_6973_746d_696e, 16'h6572, 64'h3031_3233_3435_3637,
                  32'h3839_6162, 48'h8000_0000_0000, 25'd16777217);
      send_request(32'd12345);
      send_request(32'd36);
      drain_results();
   endtask

   // receiver holds off long enough that the queue fills and req stalls
   task automatic test_backpressure();
      csr_write(REG_TARGET, 64'h0000_4000_0000_0000);
      csr_write(REG_COUNT, 64'd3);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles        = 3000;
      repeat (8) send_request(random_start());
      drain_results();
   endtask

   // random traffic under one idle setting
   task automatic test_random_phase(input int send_idle, input int recv_stall,
                                    input int items);
      logic [47:0] tgt;
      sender_idle_pct    = send_idle;
      receiver_stall_pct = recv_stall;
      case ($urandom_range(3))
         0: tgt = 48'hFFFF_FFFF_FFFF;
         1: tgt = 48'd0;
         default: tgt = {$urandom(), 16'(($urandom()))} >> $urandom_range(3, 0);
      endcase
      program_all({$urandom(), $urandom()}, 16'($urandom()), {$urandom(), $urandom()},
                  $urandom(), tgt, 25'($urandom_range(6, 1)));
      for (int i = 0; i < items; i++) begin
         send_request(random_start());
      end
      drain_results();
   endtask

   // ------------------------------------------------------------ processes

   // receiver ready: long hold-off when requested, else random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // response checker against the oldest prediction
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing pending: found %0d nonce %0d",
                     $time, rsp_found, rsp_hit_nonce);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_total++;
            if (exp_r.found) hit_count++;
            if (rsp_found !== exp_r.found) begin
               $display("%0t: found expected %0d actual %0d", $time, exp_r.found, rsp_found);
               error_count++;
            end
            if (rsp_hit_nonce !== exp_r.nonce) begin
               $display("%0t: hit_nonce expected %0d actual %0d",
                        $time, exp_r.nonce, rsp_hit_nonce);
               error_count++;
            end
            if (rsp_digest_prefix !== exp_r.prefix) begin
               $display("%0t: digest_prefix expected %h actual %h",
                        $time, exp_r.prefix, rsp_digest_prefix);
               error_count++;
            end
            if (rsp_tried_count !== exp_r.tried) begin
               $display("%0t: tried_count expected %0d actual %0d",
                        $time, exp_r.tried, rsp_tried_count);
               error_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #60000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      round_k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      iv_words = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                   32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      // reset defaults of the register file
      id_hi_q  = '0;
      id_lo_q  = '0;
      blk_hi_q = '0;
      blk_lo_q = '0;
      target_q = '0;
      count_q  = SEARCH_RESET;
      error_count        = 0;
      sent_count         = 0;
      hit_count          = 0;
      checked_total      = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles        = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_start_nonce = '0;
      rsp_ready       = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      test_directed();
      test_backpressure();
      test_random_phase(0, 0, 20);
      test_random_phase(53, 0, 20);
      test_random_phase(0, 53, 20);
      test_random_phase(23, 23, 20);

      $display("covered %0d requests, %0d responses checked, %0d hits, %0d errors",
               sent_count, checked_total, hit_count, error_count);
      $display("idle phases: none, sender gaps, receiver stalls, both, plus long hold-off");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sha256_nonce_search.f
src/sns_pkg.sv
src/sns_front.sv
src/sns_core.sv
src/sns_back.sv
src/sha256_nonce_search.sv
test/tb_top.sv
